### rtl/grfa_pkg.sv
// ----------------------------------------------------------------------------
// grfa_pkg: shared types and constants of the grid rectangle allocator
// Item structs, opcodes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package grfa_pkg;

  localparam int MAX_SIDE_DEF = 16;
  localparam int ID_BITS_DEF  = 8;

  // operation codes
  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CHECK  = 2'd3;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [4:0] SIDE_RESET = 5'd16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] item_id;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [4:0] rect_width;
    logic [4:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic       success;
    logic [3:0] found_x;
    logic [3:0] found_y;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch a new item
    logic rd;        // read the current cell
    logic wr;        // write the current cell
    logic wr_zero;   // write 0 instead of the id
    logic clr;       // clear one entry of the map
    logic step;      // advance to the next cell of the rectangle
    logic rewind;    // back to the first cell of the rectangle
    logic next_pos;  // find: next column
    logic next_row;  // find: first column of the next row
    logic res_load;  // load the output register
    logic res_ok;    // outcome to load
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       id_zero;
    logic       size_zero;
    logic       rect_fits;
    logic       row_fits;
    logic       col_fits;
    logic       cell_in_bounds;
    logic       cell_blocked;
    logic       cell_match;
    logic       cell_last;
    logic       clr_last;
  } dp_sts_t;

endpackage

### rtl/grfa_dp.sv
// ----------------------------------------------------------------------------
// grfa_dp: datapath of the grid rectangle allocator
// Owner map memory, grid registers, position counters and result register.
// ----------------------------------------------------------------------------
module grfa_dp #(
  parameter int MAX_SIDE = grfa_pkg::MAX_SIDE_DEF,
  parameter int ID_BITS  = grfa_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data,
  input  grfa_pkg::in_item_t  in_data,
  input  grfa_pkg::dp_cmd_t   cmd,
  output grfa_pkg::dp_sts_t   sts,
  output grfa_pkg::out_item_t out_data
);

  // wide enough for a position plus a full 5-bit rectangle side
  localparam int CW    = $clog2(MAX_SIDE + 32);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * CW;

  logic [4:0]         grid_columns;
  logic [4:0]         grid_rows;
  logic [1:0]         op;
  logic [ID_BITS-1:0] id;
  logic [4:0]         w;
  logic [4:0]         h;
  logic [CW-1:0]      bx;
  logic [CW-1:0]      by;
  logic [4:0]         ox;
  logic [4:0]         oy;
  logic [AW-1:0]      clr_cnt;
  logic [ID_BITS-1:0] rdata;
  logic [ID_BITS-1:0] mem [DEPTH];

  logic [CW-1:0]      cols;
  logic [CW-1:0]      rows;
  logic [CW-1:0]      cx;
  logic [CW-1:0]      cy;
  logic [PW-1:0]      addr_full;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic [ID_BITS-1:0] allow;
  logic               ox_last;
  logic               oy_last;

  // grid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= grfa_pkg::SIDE_RESET;
      grid_rows    <= grfa_pkg::SIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        grfa_pkg::REG_COLUMNS: grid_columns <= cfg_data;
        grfa_pkg::REG_ROWS:    grid_rows    <= cfg_data;
        default:               grid_columns <= grid_columns;
      endcase
    end
  end

  // clamp to 1..MAX_SIDE
  always_comb begin
    if (grid_columns == 5'd0) cols = CW'(1);
    else if (CW'(grid_columns) > CW'(MAX_SIDE)) cols = CW'(MAX_SIDE);
    else cols = CW'(grid_columns);
    if (grid_rows == 5'd0) rows = CW'(1);
    else if (CW'(grid_rows) > CW'(MAX_SIDE)) rows = CW'(MAX_SIDE);
    else rows = CW'(grid_rows);
  end

  assign cx        = bx + CW'(ox);
  assign cy        = by + CW'(oy);
  assign addr_full = PW'(cy) * PW'(MAX_SIDE) + PW'(cx);
  assign cell_addr = addr_full[AW-1:0];
  assign ox_last   = (ox + 5'd1) == w;
  assign oy_last   = (oy + 5'd1) == h;
  assign allow     = (op == grfa_pkg::OP_PLACE) ? id : '0;

  // item fields and scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data.opcode;
      id <= ID_BITS'(in_data.item_id);
      w  <= in_data.rect_width;
      h  <= in_data.rect_height;
      bx <= (in_data.opcode == grfa_pkg::OP_FIND) ? '0 : CW'(in_data.pos_x);
      by <= (in_data.opcode == grfa_pkg::OP_FIND) ? '0 : CW'(in_data.pos_y);
      ox <= '0;
      oy <= '0;
    end else if (cmd.next_row) begin
      bx <= '0;
      by <= by + CW'(1);
      ox <= '0;
      oy <= '0;
    end else if (cmd.next_pos) begin
      bx <= bx + CW'(1);
      ox <= '0;
      oy <= '0;
    end else if (cmd.rewind) begin
      ox <= '0;
      oy <= '0;
    end else if (cmd.step) begin
      if (ox_last) begin
        ox <= '0;
        oy <= oy + 5'd1;
      end else begin
        ox <= ox + 5'd1;
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // owner map
  assign wr_addr = cmd.clr ? clr_cnt : cell_addr;
  assign wr_data = (cmd.clr || cmd.wr_zero) ? '0 : id;

  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.clr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[cell_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.success <= cmd.res_ok;
      if (cmd.res_ok && op == grfa_pkg::OP_FIND) begin
        out_data.found_x <= bx[3:0];
        out_data.found_y <= by[3:0];
      end else begin
        out_data.found_x <= 4'd0;
        out_data.found_y <= 4'd0;
      end
    end
  end

  always_comb begin
    sts.op             = op;
    sts.id_zero        = (id == '0);
    sts.size_zero      = (w == 5'd0) || (h == 5'd0);
    sts.col_fits       = (bx + CW'(w)) <= cols;
    sts.row_fits       = (by + CW'(h)) <= rows;
    sts.rect_fits      = sts.col_fits && sts.row_fits;
    sts.cell_in_bounds = (cx < cols) && (cy < rows);
    sts.cell_blocked   = (rdata != '0) && (rdata != allow);
    sts.cell_match     = (rdata == id);
    sts.cell_last      = ox_last && oy_last;
    sts.clr_last       = (clr_cnt == AW'(DEPTH - 1));
  end

  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.wr && !cmd.clr |-> sts.cell_in_bounds)
    else $error("cell write outside the grid");

  a_fail_clears_spot: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load && !cmd.res_ok |=>
      !out_data.success && out_data.found_x == 4'd0 && out_data.found_y == 4'd0)
    else $error("failed item reports a spot");

endmodule

### rtl/grfa_ctrl.sv
// ----------------------------------------------------------------------------
// grfa_ctrl: controller of the grid rectangle allocator
// Sequences clearing, cell scans, writes and the search over positions.
// ----------------------------------------------------------------------------
module grfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  grfa_pkg::dp_sts_t sts,
  output grfa_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_SC_RD = 4'd3;
  localparam logic [3:0] S_SC_EV = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_RM_RD = 4'd6;
  localparam logic [3:0] S_RM_EV = 4'd7;
  localparam logic [3:0] S_F_POS = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       res_ok;
  logic       res_ok_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    res_ok_next = res_ok;
    cmd         = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        unique case (sts.op)
          grfa_pkg::OP_PLACE: begin
            if (sts.id_zero || sts.size_zero || !sts.rect_fits) begin
              res_ok_next = 1'b0;
              state_next  = S_DONE;
            end else begin
              state_next = S_SC_RD;
            end
          end
          grfa_pkg::OP_REMOVE: begin
            if (sts.id_zero || sts.size_zero) begin
              res_ok_next = !sts.id_zero;
              state_next  = S_DONE;
            end else begin
              state_next = S_RM_RD;
            end
          end
          grfa_pkg::OP_FIND: begin
            if (sts.id_zero || sts.size_zero) begin
              res_ok_next = 1'b0;
              state_next  = S_DONE;
            end else begin
              state_next = S_F_POS;
            end
          end
          grfa_pkg::OP_CHECK: begin
            if (sts.size_zero || !sts.rect_fits) begin
              res_ok_next = 1'b0;
              state_next  = S_DONE;
            end else begin
              state_next = S_SC_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SC_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SC_EV;
      end
      S_SC_EV: begin
        if (sts.cell_blocked) begin
          if (sts.op == grfa_pkg::OP_FIND) begin
            cmd.next_pos = 1'b1;
            state_next   = S_F_POS;
          end else begin
            res_ok_next = 1'b0;
            state_next  = S_DONE;
          end
        end else if (sts.cell_last) begin
          if (sts.op == grfa_pkg::OP_PLACE) begin
            cmd.rewind = 1'b1;
            state_next = S_WR;
          end else begin
            res_ok_next = 1'b1;
            state_next  = S_DONE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.cell_last) begin
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_RM_RD: begin
        if (sts.cell_in_bounds) begin
          cmd.rd     = 1'b1;
          state_next = S_RM_EV;
        end else if (sts.cell_last) begin
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_RM_EV: begin
        cmd.wr      = sts.cell_match;
        cmd.wr_zero = 1'b1;
        if (sts.cell_last) begin
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_F_POS: begin
        if (!sts.row_fits) begin
          res_ok_next = 1'b0;
          state_next  = S_DONE;
        end else if (!sts.col_fits) begin
          cmd.next_row = 1'b1;
        end else begin
          state_next = S_SC_RD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = res_ok;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      res_ok <= res_ok_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !cmd.res_load)
    else $error("result register overwritten while stalled");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_DISP && !in_stall == 1'b0)
    else $error("accepted item not dispatched");

endmodule

### rtl/grid_rectangle_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// grid_rectangle_first_fit_allocator_top: first-fit rectangle allocator
// Owner map of a grid of cells with place, remove, find and check operations.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------
//  in       | input     | in_valid / in_stall | in_data  (grfa_pkg::in_item_t)
//  out      | output    | out_valid/out_stall | out_data (grfa_pkg::out_item_t)
//  cfg      | input     | cfg_write           | cfg_index, cfg_data
//
//  Items: one at a time; the owner map has one read port with a
//  registered read, so each scanned cell takes a read state and an
//  evaluate state. Check scans the rectangle; place scans it, then writes
//  it; remove clears its cells that hold the id; find tries positions row by row.
//  Reset: synchronous; afterwards a clearing pass zeroes all MAX_SIDE*MAX_SIDE
//  map entries, one entry per cycle, with in_stall high (cfg writes work).
//  Stalls: a finished result waits in the output register while the next
//  item is accepted; the block holds in its last state until the slot frees.
//
module grid_rectangle_first_fit_allocator_top #(
  parameter int MAX_SIDE = grfa_pkg::MAX_SIDE_DEF,
  parameter int ID_BITS  = grfa_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  grfa_pkg::in_item_t  in_data,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output grfa_pkg::out_item_t out_data,
  // grid size registers
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);

  grfa_pkg::dp_cmd_t cmd;
  grfa_pkg::dp_sts_t sts;

  // sequence each item: dispatch, scan, write, report
  grfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // owner map, grid size, counters and result register
  grfa_dp #(
    .MAX_SIDE (MAX_SIDE),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
